>>> hdl/lzd_pkg.sv
// lzd_pkg: shared constants and types for the bit-flag lzss decompressor
// no dependencies
package lzd_pkg;
	localparam int WINDOW_DEPTH_DEF = 8192;
	localparam int BEAT_BYTES_DEF   = 4;
	localparam int LANES            = 4;

	typedef enum logic [3:0] {
		PH_BIT_A = 4'd0, PH_BIT_B = 4'd1, PH_BIT_C = 4'd2, PH_BIT_D = 4'd3,
		PH_LIT = 4'd4, PH_SPAN8 = 4'd5, PH_B1 = 4'd6, PH_B2 = 4'd7, PH_B3 = 4'd8
	} phase_t;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001, ST_COPY = 5'b00010, ST_WAIT = 5'b00100,
		ST_EMIT = 5'b01000, ST_DONE = 5'b10000
	} state_t;
endpackage

>>> hdl/lzd_stream_if.sv
// lzd_stream_if: valid/ready channel interfaces for input bytes and output beats
// depends on nothing
interface lzd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       start_of_stream;
	modport source (output valid, in_byte, start_of_stream, input ready);
	modport sink (input valid, in_byte, start_of_stream, output ready);
endinterface

interface lzd_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte0;
	logic [7:0] out_byte1;
	logic [7:0] out_byte2;
	logic [7:0] out_byte3;
	logic [2:0] byte_count;
	logic       last_of_run;
	logic       stream_done;
	modport source (output valid, out_byte0, out_byte1, out_byte2, out_byte3,
		byte_count, last_of_run, stream_done, input ready);
	modport sink (input valid, out_byte0, out_byte1, out_byte2, out_byte3,
		byte_count, last_of_run, stream_done, output ready);
endinterface

>>> hdl/lzss_bitflag_decompressor_core.sv
// lzss_bitflag_decompressor_core: top level, token parser, copy engine, beat packer
// depends on lzd_pkg, lzd_stream_if, lzd_history
//
// Usage: compressed bytes arrive on the in channel, one per transaction;
// start_of_stream restarts parsing (the window contents are kept).
// Decoded bytes leave on the out channel in beats of up to four bytes;
// last_of_run marks the final beat caused by one input byte, and the
// end marker gives one beat with stream_done set and byte_count 0.
// A byte that completes no token is only accepted; a literal or the end
// marker is accepted, then gives its beat. A match copies each byte
// through the history ram in ST_COPY (address) then ST_WAIT (data back
// and written), and each full or final beat is held in ST_EMIT. Only one
// input byte is handled at a time; ready stays low until all its beats
// are taken. A stalled receiver holds the beat register and the copy
// pauses. Reset clears the parse state and write position; the window ram
// holds undefined data until written. Bytes after the end marker are
// dropped with no result until start_of_stream.
module lzss_bitflag_decompressor_core import lzd_pkg::*; #(
	parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF,
	parameter int BEAT_BYTES = BEAT_BYTES_DEF
) (
	input logic clk,
	input logic arst_n,
	lzd_in_if.sink in_ch,
	lzd_out_if.source out_ch
);
	localparam int AW = $clog2(WINDOW_DEPTH);
	localparam int NL = (BEAT_BYTES < LANES) ? BEAT_BYTES : LANES;

	state_t     state_q;
	phase_t     phase_q;
	logic [15:0] flags_q;
	logic [4:0]  left_q;
	logic [7:0]  low_q;
	logic [8:0]  len_q;
	logic [15:0] span_q;
	logic [AW-1:0] wpos_q;
	logic        fin_q;
	logic [8:0]  ncopy_q;
	logic [7:0]  lane_q [LANES];
	logic [2:0]  cnt_q;
	logic [6:0]  beats_q;
	logic        doneb_q;

	logic          we;
	logic [7:0]    wdata, rdata;
	logic [AW-1:0] raddr;

	lzd_history #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_hist (
		.clk(clk), .we(we), .waddr(wpos_q), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	logic [AW-1:0] back_dist;
	always_comb begin
		back_dist = span_q[AW-1:0];
		raddr = wpos_q - back_dist;
	end

	assign in_ch.ready = (state_q == ST_IDLE);
	assign out_ch.valid = (state_q == ST_EMIT) || (state_q == ST_DONE);
	assign out_ch.out_byte0 = lane_q[0];
	assign out_ch.out_byte1 = lane_q[1];
	assign out_ch.out_byte2 = lane_q[2];
	assign out_ch.out_byte3 = lane_q[3];
	assign out_ch.byte_count = cnt_q;
	assign out_ch.stream_done = doneb_q;
	assign out_ch.last_of_run = doneb_q || (ncopy_q == 9'd0) || (beats_q == 7'd63);

	// per-byte parse, combinational view of the next state
	logic [15:0] f_n; logic [4:0] l_n; logic [7:0] lo_n; phase_t p_n;
	logic [8:0] len_n; logic [15:0] sp_n; logic fin_n;
	logic lit_n; logic [8:0] copy_n; logic [7:0] b;

	always_comb begin
		b = in_ch.in_byte;
		f_n = flags_q; l_n = left_q; lo_n = low_q; p_n = phase_q;
		len_n = len_q; sp_n = span_q; fin_n = fin_q;
		lit_n = 1'b0; copy_n = 9'd0;
		if (in_ch.start_of_stream) begin
			f_n = '0; l_n = '0; p_n = PH_BIT_A; len_n = '0; sp_n = '0; fin_n = 1'b0;
		end
		if (!fin_n) begin
			if (l_n == 5'd0) begin
				lo_n = b; l_n = 5'd17;
			end else if (l_n > 5'd16) begin
				f_n = {b, lo_n}; l_n = 5'd16;
			end else begin
				case (p_n)
					PH_LIT: begin lit_n = 1'b1; p_n = PH_BIT_A; end
					PH_SPAN8: begin
						sp_n = 16'd256 - {8'd0, b}; copy_n = len_n; p_n = PH_BIT_A;
					end
					PH_B1: begin sp_n = {8'd0, b}; p_n = PH_B2; end
					PH_B2: begin
						sp_n = 16'h0000 - ({8'd0, sp_n[7:0]} | ({8'd0, b & 8'hF8} << 5) |
							16'hE000);
						len_n = {6'd0, b[2:0]} + 9'd2;
						if (b[2:0] == 3'd0) p_n = PH_B3;
						else begin copy_n = len_n; p_n = PH_BIT_A; end
					end
					PH_B3: begin
						if (b == 8'd0) fin_n = 1'b1;
						else if (b != 8'd1) begin
							len_n = {1'b0, b} + 9'd1; copy_n = len_n;
						end
						p_n = PH_BIT_A;
					end
					default: ;
				endcase
			end
			// consume up to four flag bits
			for (int i = 0; i < 4; i++) begin
				if (!fin_n && l_n >= 5'd1 && l_n <= 5'd16 &&
				    (p_n == PH_BIT_A || p_n == PH_BIT_B || p_n == PH_BIT_C ||
				     p_n == PH_BIT_D)) begin
					logic bt;
					bt = f_n[0];
					l_n = l_n - 5'd1;
					if (l_n != 5'd0) f_n = {1'b0, f_n[15:1]};
					case (p_n)
						PH_BIT_A: p_n = bt ? PH_LIT : PH_BIT_B;
						PH_BIT_B: p_n = bt ? PH_B1 : PH_BIT_C;
						PH_BIT_C: begin len_n = {7'd0, bt, 1'b0}; p_n = PH_BIT_D; end
						default: begin len_n = len_n + {8'd0, bt} + 9'd2; p_n = PH_SPAN8; end
					endcase
				end
			end
		end
	end

	logic fin_q_eff;
	assign fin_q_eff = fin_q && !in_ch.start_of_stream;
	assign we = (state_q == ST_WAIT) || (state_q == ST_IDLE && in_ch.valid && lit_n && !fin_q_eff);
	assign wdata = (state_q == ST_WAIT) ? rdata : b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE; phase_q <= PH_BIT_A; flags_q <= '0; left_q <= '0;
			low_q <= '0; len_q <= '0; span_q <= '0; wpos_q <= '0; fin_q <= 1'b0;
			ncopy_q <= '0; cnt_q <= '0; beats_q <= '0; doneb_q <= 1'b0;
			for (int j = 0; j < LANES; j++) lane_q[j] <= '0;
		end else begin
			case (state_q)
				ST_IDLE: if (in_ch.valid) begin
					if (in_ch.start_of_stream) wpos_q <= '0;
					else if (lit_n) wpos_q <= wpos_q + 1'b1;
					if (!fin_q_eff) begin
						flags_q <= f_n; left_q <= l_n; low_q <= lo_n; phase_q <= p_n;
						len_q <= len_n; span_q <= sp_n;
						fin_q <= fin_n; beats_q <= '0;
						if (fin_n) begin
							doneb_q <= 1'b1; cnt_q <= '0;
							for (int j = 0; j < LANES; j++) lane_q[j] <= '0;
							state_q <= ST_DONE;
						end else if (lit_n) begin
							lane_q[0] <= b;
							for (int j = 1; j < LANES; j++) lane_q[j] <= '0;
							cnt_q <= 3'd1; ncopy_q <= '0;
							state_q <= ST_EMIT;
						end else begin
							cnt_q <= '0; ncopy_q <= copy_n;
							if (copy_n != 9'd0) state_q <= ST_COPY;
						end
					end else fin_q <= 1'b1;
				end
				ST_COPY: state_q <= ST_WAIT;
				ST_WAIT: begin
					lane_q[cnt_q[1:0]] <= rdata;
					wpos_q <= wpos_q + 1'b1;
					ncopy_q <= ncopy_q - 9'd1;
					cnt_q <= cnt_q + 3'd1;
					if (cnt_q + 3'd1 == 3'(NL) || ncopy_q == 9'd1) state_q <= ST_EMIT;
					else state_q <= ST_COPY;
				end
				ST_EMIT: if (out_ch.ready) begin
					cnt_q <= '0;
					for (int j = 0; j < LANES; j++) lane_q[j] <= '0;
					beats_q <= beats_q + 7'd1;
					if (ncopy_q == 9'd0) state_q <= ST_IDLE;
					else if (beats_q == 7'd63) begin
						wpos_q <= wpos_q + AW'(ncopy_q);
						ncopy_q <= '0; state_q <= ST_IDLE;
					end else state_q <= ST_COPY;
				end
				ST_DONE: if (out_ch.ready) begin
					doneb_q <= 1'b0; state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

>>> hdl/lzd_history.sv
// lzd_history: history window ram, one write and one registered read port
// depends on lzd_pkg
module lzd_history import lzd_pkg::*; #(
	parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF,
	localparam int AW = $clog2(WINDOW_DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);
	logic [7:0] mem [WINDOW_DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

>>> sim/lzss_bitflag_decompressor_core_tb.sv
// lzss_bitflag_decompressor_core_tb: self-checking bench for the bit-flag lzss decompressor
// encodes legal token streams, predicts the output beats and checks each out transaction
// depends on lzd_pkg, lzd_stream_if and the core rtl
module lzss_bitflag_decompressor_core_tb import lzd_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WIN = WINDOW_DEPTH_DEF;
	localparam int CYCLE_LIMIT = 10000000;
	localparam int STALL_CYCLES = 400;

	typedef struct {
		logic [7:0] b0, b1, b2, b3;
		logic [2:0] cnt;
		logic       last;
		logic       done;
	} beat_t;

	logic clk = 1'b0;
	logic arst_n;
	lzd_in_if  in_ch();
	lzd_out_if out_ch();

	lzss_bitflag_decompressor_core u_top (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch)
	);

	always #5 clk = ~clk;

	// decoder shadow state
	logic [15:0] fb;
	logic [4:0]  fleft;
	logic [7:0]  rlow;
	phase_t      ph;
	logic [8:0]  plen;
	logic [13:0] pspan;
	logic [7:0]  win [WIN];
	logic [12:0] wp;
	bit          fin;
	logic [7:0]  run_q[$];
	beat_t       beat_q[$];

	// encoder side: which window entries are written, and where the stream writes next
	bit          gen_written [WIN];
	logic [12:0] gen_wp;
	logic [7:0]  str_q[$];
	int          slot_idx;
	logic [15:0] wv;
	int          wcnt;

	int  items_sent, streams_sent;
	int  beats_checked = 0;
	int  errors = 0;
	int  cycles = 0;
	int  stall_req = 0;
	int  stall_seen;
	int  stall_hold;
	bit  burst;
	int  rgap;

	function automatic int draw_gap();
		if (burst) return 0;
		return ($urandom_range(0, 2) == 0) ? $urandom_range(0, 18) : 0;
	endfunction

	// ---------------- prediction ----------------
	function automatic void hist_put(logic [7:0] v);
		win[wp] = v;
		wp = wp + 13'd1;
		run_q.insert(run_q.size(), v);
	endfunction

	function automatic void copy_from_window();
		int d;
		d = int'(pspan) % WIN;
		if (d == 0) d = WIN;
		for (int i = 0; i < int'(plen); i++)
			hist_put(win[(int'(wp) + WIN - d) % WIN]);
	endfunction

	function automatic void run_flag_bits();
		logic b;
		while (fleft >= 1 && fleft <= 16 && ph <= PH_BIT_D) begin
			b = fb[0];
			fleft = fleft - 5'd1;
			if (fleft != 0) fb = fb >> 1;
			case (ph)
				PH_BIT_A: ph = b ? PH_LIT : PH_BIT_B;
				PH_BIT_B: ph = b ? PH_B1 : PH_BIT_C;
				PH_BIT_C: begin
					plen = {7'd0, b, 1'b0};
					ph = PH_BIT_D;
				end
				default: begin
					plen = (plen | {8'd0, b}) + 9'd2;
					ph = PH_SPAN8;
				end
			endcase
		end
	endfunction

	function automatic void take_data(logic [7:0] v);
		int code;
		case (ph)
			PH_LIT: begin
				hist_put(v);
				ph = PH_BIT_A;
			end
			PH_SPAN8: begin
				pspan = 14'(256 - int'(v));
				copy_from_window();
				ph = PH_BIT_A;
			end
			PH_B1: begin
				pspan = {6'd0, v};
				ph = PH_B2;
			end
			PH_B2: begin
				code = int'(pspan[7:0]) | ((int'(v) & 'hF8) << 5) | 'hE000;
				pspan = 14'('h10000 - code);
				plen = 9'((int'(v) & 7) + 2);
				if (plen == 9'd2) begin
					ph = PH_B3;
				end else begin
					copy_from_window();
					ph = PH_BIT_A;
				end
			end
			PH_B3: begin
				if (v == 8'd0) begin
					fin = 1'b1;
				end else if (v != 8'd1) begin
					plen = 9'(int'(v) + 1);
					copy_from_window();
				end
				ph = PH_BIT_A;
			end
			default: ;
		endcase
	endfunction

	function automatic void predict_beats(logic [7:0] v, logic sos);
		beat_t bt;
		int pos, n;
		run_q.delete();
		if (sos) begin
			fb = '0; fleft = '0; ph = PH_BIT_A; plen = '0; pspan = '0; wp = '0; fin = 1'b0;
		end
		if (fin) return;
		if (fleft == 0) begin
			rlow = v;
			fleft = 5'd17;
		end else if (fleft > 16) begin
			fb = {v, rlow};
			fleft = 5'd16;
			run_flag_bits();
		end else begin
			take_data(v);
			if (fin) begin
				bt = '{8'd0, 8'd0, 8'd0, 8'd0, 3'd0, 1'b1, 1'b1};
				beat_q.insert(beat_q.size(), bt);
				return;
			end
			run_flag_bits();
		end
		pos = 0;
		while (pos < run_q.size()) begin
			n = run_q.size() - pos;
			if (n > LANES) n = LANES;
			bt.b0 = run_q[pos];
			bt.b1 = (n > 1) ? run_q[pos + 1] : 8'd0;
			bt.b2 = (n > 2) ? run_q[pos + 2] : 8'd0;
			bt.b3 = (n > 3) ? run_q[pos + 3] : 8'd0;
			bt.cnt = 3'(n);
			pos += n;
			bt.last = (pos >= run_q.size());
			bt.done = 1'b0;
			beat_q.insert(beat_q.size(), bt);
		end
	endfunction

	// ---------------- stream encoder ----------------
	function automatic void stream_add(logic [7:0] v);
		str_q.insert(str_q.size(), v);
	endfunction

	function automatic void reserve_word();
		wv = 16'($urandom);
		wcnt = 0;
		slot_idx = str_q.size();
		stream_add(wv[7:0]);
		stream_add(wv[15:8]);
	endfunction

	function automatic void put_bit(logic b);
		wv[wcnt] = b;
		wcnt++;
		str_q[slot_idx] = wv[7:0];
		str_q[slot_idx + 1] = wv[15:8];
		if (wcnt == 16) reserve_word();
	endfunction

	function automatic void mark_written(int len);
		for (int i = 0; i < len; i++) begin
			gen_written[gen_wp] = 1'b1;
			gen_wp = gen_wp + 13'd1;
		end
	endfunction

	function automatic bit hist_ok(int span, int len);
		int n;
		n = (len < span) ? len : span;
		for (int k = 0; k < n; k++)
			if (!gen_written[(int'(gen_wp) - span + k + WIN) % WIN]) return 1'b0;
		return 1'b1;
	endfunction

	function automatic int pick_dist(int len, int maxd);
		int d;
		repeat (6) begin
			d = $urandom_range(0, 1) ? $urandom_range(1, maxd) : $urandom_range(1, 16);
			if (d <= maxd && hist_ok(d, len)) return d;
		end
		return 0;
	endfunction

	function automatic void enc_begin();
		str_q.delete();
		gen_wp = '0;
		reserve_word();
	endfunction

	function automatic void tok_lit(logic [7:0] v);
		put_bit(1'b1);
		stream_add(v);
		mark_written(1);
	endfunction

	function automatic void tok_short(int len, int span);
		put_bit(1'b0);
		put_bit(1'b0);
		put_bit(1'((len - 2) >> 1));
		put_bit(1'(len - 2));
		stream_add(8'(256 - span));
		mark_written(len);
	endfunction

	// b3 carries the length when ext is set, else the low bits of b2 do
	function automatic void tok_long(int len, int span, bit ext);
		logic [15:0] code;
		code = 16'('h10000 - span);
		put_bit(1'b0);
		put_bit(1'b1);
		stream_add(code[7:0]);
		if (ext) begin
			stream_add({code[12:8], 3'd0});
			stream_add(8'(len - 1));
		end else begin
			stream_add({code[12:8], 3'(len - 2)});
		end
		mark_written(len);
	endfunction

	function automatic void tok_marker(logic [7:0] b3);
		put_bit(1'b0);
		put_bit(1'b1);
		stream_add(8'($urandom));
		stream_add({5'($urandom), 3'd0});
		stream_add(b3);
	endfunction

	// ---------------- channels ----------------
	task automatic send_byte(logic [7:0] v, logic sos);
		int g;
		g = draw_gap();
		if (g > 0) begin
			in_ch.valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.in_byte <= v;
		in_ch.start_of_stream <= sos;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		predict_beats(v, sos);
		items_sent++;
	endtask

	task automatic send_stream(int trailing);
		for (int i = 0; i < str_q.size(); i++) send_byte(str_q[i], i == 0);
		repeat (trailing) send_byte(8'($urandom), 1'b0);
		streams_sent++;
	endtask

	task automatic wait_drain();
		in_ch.valid <= 1'b0;
		while (beat_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			rgap = 0;
			stall_hold = 0;
			stall_seen = stall_req;
		end else if (stall_seen != stall_req) begin
			stall_seen = stall_req;
			stall_hold = STALL_CYCLES;
			out_ch.ready <= 1'b0;
		end else if (stall_hold > 0) begin
			stall_hold--;
			out_ch.ready <= 1'b0;
		end else if (out_ch.valid && out_ch.ready) begin
			rgap = draw_gap();
			if (rgap > 0) out_ch.ready <= 1'b0;
		end else if (rgap > 0) begin
			rgap--;
		end else begin
			out_ch.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		beat_t e;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (beat_q.size() == 0) begin
				$display("%0t: unexpected beat cnt=%0d done=%0b", $time,
					out_ch.byte_count, out_ch.stream_done);
				errors++;
			end else begin
				e = beat_q.pop_front();
				beats_checked++;
				if (out_ch.out_byte0 !== e.b0 || out_ch.out_byte1 !== e.b1 ||
					out_ch.out_byte2 !== e.b2 || out_ch.out_byte3 !== e.b3 ||
					out_ch.byte_count !== e.cnt || out_ch.last_of_run !== e.last ||
					out_ch.stream_done !== e.done) begin
					$display("%0t: beat mismatch exp %h %h %h %h cnt=%0d last=%0b done=%0b",
						$time, e.b0, e.b1, e.b2, e.b3, e.cnt, e.last, e.done);
					$display("%0t:                got %h %h %h %h cnt=%0d last=%0b done=%0b",
						$time, out_ch.out_byte0, out_ch.out_byte1, out_ch.out_byte2,
						out_ch.out_byte3, out_ch.byte_count, out_ch.last_of_run,
						out_ch.stream_done);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d beats outstanding", cycles, beat_q.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	// ---------------- tests ----------------
	task automatic test_directed();
		enc_begin();
		tok_lit(8'h00);
		tok_lit(8'hFF);
		tok_lit(8'($urandom));
		for (int len = 2; len <= 5; len++) tok_short(len, len - 1);
		tok_long(9, 2, 1'b0);
		tok_long(256, 1, 1'b1);
		tok_marker(8'd1);
		tok_short(2, 256);
		tok_long(3, 7, 1'b1);
		tok_marker(8'd0);
		send_stream(2);
		wait_drain();
	endtask

	task automatic test_full_window();
		enc_begin();
		tok_lit(8'($urandom));
		repeat (33) tok_long(256, 1, 1'b1);
		tok_lit(8'($urandom));
		tok_long(4, WIN, 1'b1);
		tok_long(9, WIN - 3, 1'b0);
		tok_marker(8'd0);
		send_stream(0);
		wait_drain();
	endtask

	task automatic rand_stream(int ntok, bit terminate);
		int r, len, d;
		enc_begin();
		tok_lit(8'($urandom));
		repeat (ntok) begin
			r = $urandom_range(0, 99);
			d = 0;
			if (r < 30) begin
				len = 1;
			end else if (r < 55) begin
				len = $urandom_range(2, 5);
				d = pick_dist(len, 256);
				if (d != 0) tok_short(len, d);
			end else if (r < 75) begin
				len = $urandom_range(3, 9);
				d = pick_dist(len, WIN);
				if (d != 0) tok_long(len, d, 1'b0);
			end else if (r < 92) begin
				len = ($urandom_range(0, 3) == 0) ? $urandom_range(3, 256) : $urandom_range(3, 40);
				d = pick_dist(len, WIN);
				if (d != 0) tok_long(len, d, 1'b1);
			end else begin
				tok_marker(8'd1);
				d = -1;
			end
			if (d == 0) tok_lit(8'($urandom));
		end
		if (terminate) tok_marker(8'd0);
		send_stream(terminate ? $urandom_range(0, 2) : 0);
	endtask

	task automatic test_random(int n_items);
		int base;
		base = items_sent;
		while (items_sent - base < n_items) begin
			burst = ($urandom_range(0, 4) == 0);
			rand_stream($urandom_range(3, 25), $urandom_range(0, 5) != 0);
		end
		burst = 1'b0;
		wait_drain();
	endtask

	task automatic test_backpressure();
		stall_req++;
		rand_stream(20, 1'b1);
		wait_drain();
		burst = 1'b1;
		rand_stream(20, 1'b1);
		burst = 1'b0;
		wait_drain();
	endtask

	initial begin
		arst_n <= 1'b0;
		in_ch.valid <= 1'b0;
		in_ch.in_byte <= '0;
		in_ch.start_of_stream <= 1'b0;
		for (int i = 0; i < WIN; i++) gen_written[i] = 1'b0;
		fb = '0; fleft = '0; rlow = '0; ph = PH_BIT_A; plen = '0; pspan = '0;
		wp = '0; fin = 1'b0;
		items_sent = 0; streams_sent = 0;
		burst = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_full_window();
		test_backpressure();
		test_random(240);

		wait_drain();
		repeat (50) @(posedge clk);
		$display("run covered %0d streams, %0d compressed bytes, %0d beats compared",
			streams_sent, items_sent, beats_checked);
		$display("literals, short and long copies, skip and end codes, full-window reach");
		if (errors == 0 && beat_q.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("%0d errors, %0d beats never seen", errors, beat_q.size());
			$display("*** FAILED ***");
		end
		$finish;
	end
endmodule
